FILE: rtl/core/mdes_pkg.sv
package mdes_pkg;

  // Round structure and storage sizes
  localparam int ROUND_COUNT = 17;
  localparam int RK_AW       = $clog2(ROUND_COUNT);
  localparam int RK_W        = 48;
  localparam logic [RK_AW-1:0] LAST_ROUND = RK_AW'(ROUND_COUNT - 1);

  // Chaining start value and the two mixing constants of this variant
  localparam logic [63:0] CBC_IV    = 64'd5597;
  localparam logic [55:0] KEY_MIX   = 56'd3543654654623;
  localparam logic [31:0] ROUND_MIX = 32'd3436547;

  // Payload words
  typedef struct packed {
    logic [63:0] cipher_block;
    logic        last_block;
  } in_word_t;

  typedef struct packed {
    logic [63:0] plain_block;
    logic        end_of_message;
  } out_word_t;

  // Subkey store write port
  typedef struct packed {
    logic             en;
    logic [RK_AW-1:0] addr;
    logic [RK_W-1:0]  data;
  } rk_wr_t;

  // Bit selection tables, 1-based from the most significant bit
  localparam logic [6:0] IP_TAB [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7};

  localparam logic [6:0] FP_TAB [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25};

  // Altered expansion table
  localparam logic [5:0] E_TAB [48] = '{
    6'd1,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
    6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd29, 6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
    6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
    6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd28, 6'd25, 6'd26, 6'd27, 6'd28, 6'd8,
    6'd24, 6'd29, 6'd30, 6'd31, 6'd32, 6'd32};

  localparam logic [5:0] P_TAB [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25};

  localparam logic [6:0] PC1_TAB [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4};

  localparam logic [5:0] PC2_TAB [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
    6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
    6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
    6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
    6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32};

  // Rotation of each schedule step, one or two places
  localparam logic [1:0] ROT_TAB [ROUND_COUNT] = '{
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1,
    2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1};

  localparam logic [3:0] SBOX [8][64] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd15,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd4,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd14,4'd15,4'd11,4'd3,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

  function automatic logic [63:0] ip_perm(logic [63:0] src);
    logic [63:0] d;
    for (int i = 0; i < 64; i++) d[63-i] = src[64 - int'(IP_TAB[i])];
    return d;
  endfunction

  function automatic logic [63:0] fp_perm(logic [63:0] src);
    logic [63:0] d;
    for (int i = 0; i < 64; i++) d[63-i] = src[64 - int'(FP_TAB[i])];
    return d;
  endfunction

  function automatic logic [47:0] e_expand(logic [31:0] src);
    logic [47:0] d;
    for (int i = 0; i < 48; i++) d[47-i] = src[32 - int'(E_TAB[i])];
    return d;
  endfunction

  function automatic logic [31:0] p_perm(logic [31:0] src);
    logic [31:0] d;
    for (int i = 0; i < 32; i++) d[31-i] = src[32 - int'(P_TAB[i])];
    return d;
  endfunction

  function automatic logic [55:0] pc1_sel(logic [63:0] src);
    logic [55:0] d;
    for (int i = 0; i < 56; i++) d[55-i] = src[64 - int'(PC1_TAB[i])];
    return d;
  endfunction

  function automatic logic [47:0] pc2_sel(logic [55:0] src);
    logic [47:0] d;
    for (int i = 0; i < 48; i++) d[47-i] = src[56 - int'(PC2_TAB[i])];
    return d;
  endfunction

  // Rotate a 28-bit half left by one or two places
  function automatic logic [27:0] rot28(logic [27:0] v, logic [1:0] r);
    logic [27:0] d;
    if (r == 2'd2) begin
      d = {v[25:0], v[27:26]};
    end else begin
      d = {v[26:0], v[27]};
    end
    return d;
  endfunction

  // Round function: expand, key mix, eight S-boxes, permute, constant mix
  function automatic logic [31:0] round_f(logic [31:0] r, logic [RK_W-1:0] sk);
    logic [47:0] x;
    logic [5:0]  six;
    logic [31:0] s;
    x = e_expand(r) ^ sk;
    s = '0;
    for (int j = 0; j < 8; j++) begin
      six = x[47-6*j -: 6];
      s[31-4*j -: 4] = SBOX[j][{six[5], six[0], six[4:1]}];
    end
    return p_perm(s) ^ ROUND_MIX;
  endfunction

endpackage

FILE: rtl/core/mdes_key_store.sv
module mdes_key_store (
  input  logic                        clk_i,
  input  mdes_pkg::rk_wr_t            wr_i,
  input  logic [mdes_pkg::RK_AW-1:0]  rd_addr_i,
  output logic [mdes_pkg::RK_W-1:0]   rd_data_o
);
  import mdes_pkg::*;

  logic [RK_W-1:0] mem_q [ROUND_COUNT];
  logic [RK_W-1:0] rd_data_q;

  // Write one subkey per cycle from the schedule
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Register the read word
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/core/mdes_key_sched.sv
module mdes_key_sched (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              key_we_i,
  input  logic [63:0]       key_i,
  output logic              busy_o,
  output mdes_pkg::rk_wr_t  wr_o
);
  import mdes_pkg::*;

  logic             busy_q, busy_d;
  logic [RK_AW-1:0] idx_q, idx_d;
  logic [27:0]      c_q, c_d, d_q, d_d;
  logic [55:0]      pc1_key;
  logic [27:0]      c_rot, d_rot;

  // Rotate both halves by this step's amount and form the subkey
  always_comb begin
    pc1_key = pc1_sel(key_i);
    c_rot   = rot28(c_q, ROT_TAB[idx_q]);
    d_rot   = rot28(d_q, ROT_TAB[idx_q]);
    wr_o.en   = busy_q;
    wr_o.addr = idx_q;
    wr_o.data = pc2_sel({c_rot, d_rot} ^ KEY_MIX);
  end

  // Load on key write, then advance one subkey per cycle
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    c_d    = c_q;
    d_d    = d_q;
    if (key_we_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      c_d    = pc1_key[55:28];
      d_d    = pc1_key[27:0];
    end else if (busy_q) begin
      c_d   = c_rot;
      d_d   = d_rot;
      idx_d = idx_q + 1'b1;
      if (idx_q == LAST_ROUND) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
    d_q <= d_d;
  end

  assign busy_o = busy_q;

endmodule

FILE: rtl/core/mdes_round_eng.sv
module mdes_round_eng (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  mdes_pkg::in_word_t          in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output mdes_pkg::out_word_t         out_word_o,
  input  logic                        hold_i,
  output logic                        idle_o,
  output logic [mdes_pkg::RK_AW-1:0]  rk_addr_o,
  input  logic [mdes_pkg::RK_W-1:0]   rk_data_i
);
  import mdes_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e           state_q;
  logic [RK_AW-1:0] cnt_q;
  logic [31:0]      l_q, r_q;
  logic [63:0]      blk_q;
  logic             last_q;
  logic [63:0]      chain_q;
  logic             out_valid_q;
  out_word_t        out_q;

  logic        in_acc;
  logic        finish;
  logic [63:0] ip_blk;
  logic [31:0] r_new;

  // Handshake, round datapath and subkey read address
  always_comb begin
    in_stall_o = (state_q != ST_IDLE) || hold_i;
    in_acc     = in_valid_i && !in_stall_o;
    finish     = (state_q == ST_RUN) && (cnt_q == '0) && (!out_valid_q || !out_stall_i);
    ip_blk     = ip_perm(in_word_i.cipher_block);
    r_new      = l_q ^ round_f(r_q, rk_data_i);
    if (state_q == ST_IDLE) begin
      rk_addr_o = LAST_ROUND;
    end else if (cnt_q == '0) begin
      rk_addr_o = '0;
    end else begin
      rk_addr_o = cnt_q - 1'b1;
    end
  end

  // Sequence the rounds, hold the result word, update the chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      chain_q     <= CBC_IV;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !finish) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            l_q     <= ip_blk[63:32];
            r_q     <= ip_blk[31:0];
            blk_q   <= in_word_i.cipher_block;
            last_q  <= in_word_i.last_block;
            cnt_q   <= LAST_ROUND;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (cnt_q != '0) begin
            l_q   <= r_q;
            r_q   <= r_new;
            cnt_q <= cnt_q - 1'b1;
          end else if (finish) begin
            out_q.plain_block    <= fp_perm({r_new, r_q}) ^ chain_q;
            out_q.end_of_message <= last_q;
            out_valid_q          <= 1'b1;
            chain_q              <= last_q ? CBC_IV : blk_q;
            state_q              <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign idle_o      = (state_q == ST_IDLE);

endmodule

FILE: rtl/core/modified_des_cbc_decrypt.sv
// A single round unit takes one subkey per cycle from the 17-entry subkey memory
// and takes no new block until it has finished the last one.
// A key write rebuilds the subkey memory; input stalls meanwhile.
// Reset: chaining value loads the IV, control clears; subkeys are undefined
// until the first key write.
module modified_des_cbc_decrypt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mdes_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mdes_pkg::out_word_t  out_word_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [63:0]          cfg_data_i
);
  import mdes_pkg::*;

  logic             key_busy;
  logic             eng_idle;
  logic             key_we;
  rk_wr_t           rk_wr;
  logic [RK_AW-1:0] rk_addr;
  logic [RK_W-1:0]  rk_data;

  // Take a key word only while no block is in the round unit
  assign cfg_ready_o = !key_busy && eng_idle;
  assign key_we      = cfg_valid_i && cfg_ready_o;

  mdes_key_sched u_key_sched (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .key_we_i (key_we),
    .key_i    (cfg_data_i),
    .busy_o   (key_busy),
    .wr_o     (rk_wr)
  );

  mdes_key_store u_key_store (
    .clk_i     (clk_i),
    .wr_i      (rk_wr),
    .rd_addr_i (rk_addr),
    .rd_data_o (rk_data)
  );

  mdes_round_eng u_round_eng (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .hold_i      (key_busy || cfg_valid_i),
    .idle_o      (eng_idle),
    .rk_addr_o   (rk_addr),
    .rk_data_i   (rk_data)
  );

endmodule

FILE: rtl/core/mdes_checker.sv
module mdes_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input mdes_pkg::out_word_t  out_word_o,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o
);

  logic in_acc;
  logic cfg_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  // One block at a time in the round unit
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input taken while a block is in progress");

  // No result appears right after a block enters
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_o))
    else $error("result word appeared too early");

  // Key write and block entry never share an edge
  a_cfg_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_acc |-> in_stall_o)
    else $error("key write and input word taken together");

  // Subkey rebuild blocks both channels on the next cycle
  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_acc |=> in_stall_o && !cfg_ready_o)
    else $error("channel open during subkey rebuild");

endmodule

bind modified_des_cbc_decrypt mdes_checker u_mdes_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);
